@@ design/sdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted dictionary transform package
// Shared sizes, operation codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int MAX_UNIQUE   = 1024;
  localparam int VALUE_BITS   = 32;
  localparam int ADDR_W       = $clog2(MAX_UNIQUE);
  localparam int COUNT_W      = $clog2(MAX_UNIQUE + 1);
  localparam int LIMIT_NARROW = 256;
  localparam int LIMIT_MID    = 65536;

  localparam int OP_W      = 2;
  localparam int IN_VAL_W  = 32;
  localparam int INDEX_W   = 10;
  localparam int RANK_W    = 11;
  localparam int ENTRY_W   = 32;
  localparam int UCOUNT_W  = 11;
  localparam int WCODE_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_RANK   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [WCODE_W-1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2
  } width_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SHIFT,
    ST_MOVE,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic probe;
    logic compare;
    logic set_overflow;
    logic shift_read;
    logic shift_write;
    logic store;
    logic read_index;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic search_done;
    logic found;
    logic full;
    logic shift_done;
  } status_t;

  function automatic width_code_t width_of(input logic [COUNT_W-1:0] n);
    logic [31:0] n_ext;
    n_ext = 32'(n);
    if (n_ext <= 32'(LIMIT_NARROW)) begin
      return WIDTH_8;
    end else if (n_ext <= 32'(LIMIT_MID)) begin
      return WIDTH_16;
    end
    return WIDTH_32;
  endfunction

endpackage

@@ design/sdt_if.sv @@
// ----------------------------------------------------------------------------
// Sorted dictionary transform channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface sdt_in_if (input logic clk);
  logic                          valid;
  logic                          ready;
  logic [sdt_pkg::OP_W-1:0]      op;
  logic [sdt_pkg::IN_VAL_W-1:0]  value;
  logic [sdt_pkg::INDEX_W-1:0]   index;

  modport source (input clk, output valid, output op, output value, output index, input ready);
  modport sink (input clk, input valid, input op, input value, input index, output ready);
endinterface

interface sdt_out_if (input logic clk);
  logic                          valid;
  logic                          ready;
  logic [sdt_pkg::RANK_W-1:0]    rank;
  logic [sdt_pkg::ENTRY_W-1:0]   entry_value;
  logic [sdt_pkg::UCOUNT_W-1:0]  unique_count;
  logic [sdt_pkg::WCODE_W-1:0]   width_code;
  logic                          hit;
  logic                          overflow;

  modport source (
    input clk, output valid, output rank, output entry_value, output unique_count,
    output width_code, output hit, output overflow, input ready
  );
  modport sink (
    input clk, input valid, input rank, input entry_value, input unique_count,
    input width_code, input hit, input overflow, output ready
  );
endinterface

@@ design/sorted_dictionary_transform.sv @@
// Order of work: clear goes straight to finish, read passes the read state, and rank runs
// the binary search (a probe and a compare per step). An insert of a new value into a table
// that is not full also moves each entry above its place up (a read and a write per entry),
// then stores the value. One beat is in work at a time; the search and the shift set its length.
// A new beat is taken while the previous result still waits at the output register.
// Reset (rst, synchronous) empties the table count; the table memory itself is not cleared.
// ----------------------------------------------------------------------------
// Sorted dictionary transform
// Keeps an ascending table of distinct values and serves clear, insert, rank
// and read requests, one result beat per request beat.
// ----------------------------------------------------------------------------
module sorted_dictionary_transform (
  input  logic        clk,
  input  logic        rst,
  sdt_in_if.sink      in_ch,
  sdt_out_if.source   out_ch
);

  sdt_pkg::cmd_t    cmd;
  sdt_pkg::status_t status;

  sdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sdt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_op        (in_ch.op),
    .in_value     (in_ch.value),
    .in_index     (in_ch.index),
    .rank         (out_ch.rank),
    .entry_value  (out_ch.entry_value),
    .unique_count (out_ch.unique_count),
    .width_code   (out_ch.width_code),
    .hit          (out_ch.hit),
    .overflow     (out_ch.overflow)
  );

endmodule

@@ design/sdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted dictionary transform controller
// Sequences the binary search, the entry shift of an insert, table reads and
// the hand-off of each result beat.
// ----------------------------------------------------------------------------
module sdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sdt_pkg::status_t  status,
  output sdt_pkg::cmd_t     cmd
);

  sdt_pkg::state_t state;
  sdt_pkg::state_t state_next;
  logic            out_valid_next;
  logic            can_finish;

  assign can_finish = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (sdt_pkg::op_t'(in_op))
            sdt_pkg::OP_CLEAR: state_next = sdt_pkg::ST_FINISH;
            sdt_pkg::OP_READ:  state_next = sdt_pkg::ST_READ;
            default:           state_next = sdt_pkg::ST_SEARCH;
          endcase
        end
      end
      sdt_pkg::ST_SEARCH: begin
        if (!status.search_done) begin
          state_next = sdt_pkg::ST_COMPARE;
        end else if (status.op == sdt_pkg::OP_RANK || status.found || status.full) begin
          state_next = sdt_pkg::ST_FINISH;
        end else begin
          state_next = sdt_pkg::ST_SHIFT;
        end
      end
      sdt_pkg::ST_COMPARE: state_next = sdt_pkg::ST_SEARCH;
      sdt_pkg::ST_SHIFT: begin
        state_next = status.shift_done ? sdt_pkg::ST_FINISH : sdt_pkg::ST_MOVE;
      end
      sdt_pkg::ST_MOVE: state_next = sdt_pkg::ST_SHIFT;
      sdt_pkg::ST_READ: state_next = sdt_pkg::ST_FINISH;
      sdt_pkg::ST_FINISH: begin
        if (can_finish) begin
          state_next = sdt_pkg::ST_IDLE;
        end
      end
      default: state_next = sdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      sdt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.clear = (sdt_pkg::op_t'(in_op) == sdt_pkg::OP_CLEAR);
        end
      end
      sdt_pkg::ST_SEARCH: begin
        if (!status.search_done) begin
          cmd.probe = 1'b1;
        end else if (status.op == sdt_pkg::OP_INSERT && !status.found && status.full) begin
          cmd.set_overflow = 1'b1;
        end
      end
      sdt_pkg::ST_COMPARE: cmd.compare = 1'b1;
      sdt_pkg::ST_SHIFT: begin
        if (status.shift_done) begin
          cmd.store = 1'b1;
        end else begin
          cmd.shift_read = 1'b1;
        end
      end
      sdt_pkg::ST_MOVE: cmd.shift_write = 1'b1;
      sdt_pkg::ST_READ: cmd.read_index = 1'b1;
      sdt_pkg::ST_FINISH: begin
        if (can_finish) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ design/sdt_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted dictionary transform datapath
// Holds the sorted table memory, the entry count, the search bounds, the
// shift pointer and the result register.
// ----------------------------------------------------------------------------
module sdt_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sdt_pkg::cmd_t                     cmd,
  output sdt_pkg::status_t                  status,
  input  logic [sdt_pkg::OP_W-1:0]          in_op,
  input  logic [sdt_pkg::IN_VAL_W-1:0]      in_value,
  input  logic [sdt_pkg::INDEX_W-1:0]       in_index,
  output logic [sdt_pkg::RANK_W-1:0]        rank,
  output logic [sdt_pkg::ENTRY_W-1:0]       entry_value,
  output logic [sdt_pkg::UCOUNT_W-1:0]      unique_count,
  output logic [sdt_pkg::WCODE_W-1:0]       width_code,
  output logic                              hit,
  output logic                              overflow
);

  logic [sdt_pkg::VALUE_BITS-1:0] table_mem [sdt_pkg::MAX_UNIQUE];
  logic [sdt_pkg::VALUE_BITS-1:0] rdata;
  logic [sdt_pkg::ADDR_W-1:0]     rd_addr;
  logic                           rd_en;
  logic [sdt_pkg::ADDR_W-1:0]     wr_addr;
  logic [sdt_pkg::VALUE_BITS-1:0] wr_data;
  logic                           wr_en;

  logic [sdt_pkg::COUNT_W-1:0]    count;
  sdt_pkg::op_t                   op_r;
  logic [sdt_pkg::VALUE_BITS-1:0] value_r;
  logic [sdt_pkg::INDEX_W-1:0]    index_r;
  logic [sdt_pkg::COUNT_W-1:0]    lo;
  logic [sdt_pkg::COUNT_W-1:0]    hi;
  logic [sdt_pkg::COUNT_W-1:0]    mid;
  logic [sdt_pkg::COUNT_W-1:0]    shift_ptr;
  logic [sdt_pkg::COUNT_W-1:0]    shift_src;
  logic                           eq_flag;
  logic                           ovf_flag;
  logic                           found;
  logic                           index_ok;

  assign mid       = lo + ((hi - lo) >> 1);
  assign shift_src = shift_ptr - 1'b1;
  assign found     = (lo < count) && eq_flag;
  assign index_ok  = (sdt_pkg::COUNT_W'(index_r) < count);

  assign status.op          = op_r;
  assign status.search_done = (lo >= hi);
  assign status.found       = found;
  assign status.full        = (count >= sdt_pkg::COUNT_W'(sdt_pkg::MAX_UNIQUE));
  assign status.shift_done  = (shift_ptr == lo);

  always_comb begin
    rd_en   = cmd.probe || cmd.shift_read || cmd.read_index;
    rd_addr = mid[sdt_pkg::ADDR_W-1:0];
    if (cmd.shift_read) begin
      rd_addr = shift_src[sdt_pkg::ADDR_W-1:0];
    end else if (cmd.read_index) begin
      rd_addr = sdt_pkg::ADDR_W'(index_r);
    end
    wr_en   = cmd.shift_write || cmd.store;
    wr_addr = shift_ptr[sdt_pkg::ADDR_W-1:0];
    wr_data = rdata;
    if (cmd.store) begin
      wr_addr = lo[sdt_pkg::ADDR_W-1:0];
      wr_data = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= sdt_pkg::op_t'(in_op);
      value_r   <= in_value[sdt_pkg::VALUE_BITS-1:0];
      index_r   <= in_index;
      lo        <= '0;
      hi        <= count;
      shift_ptr <= count;
      eq_flag   <= 1'b0;
      ovf_flag  <= 1'b0;
    end else begin
      if (cmd.compare) begin
        if (rdata < value_r) begin
          lo <= mid + 1'b1;
        end else begin
          hi      <= mid;
          eq_flag <= (rdata == value_r);
        end
      end
      if (cmd.set_overflow) begin
        ovf_flag <= 1'b1;
      end
      if (cmd.shift_write) begin
        shift_ptr <= shift_src;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique_count <= sdt_pkg::UCOUNT_W'(count);
      width_code   <= sdt_pkg::width_of(count);
      overflow     <= ovf_flag;
      case (op_r)
        sdt_pkg::OP_INSERT, sdt_pkg::OP_RANK: begin
          rank        <= sdt_pkg::RANK_W'(lo);
          entry_value <= '0;
          hit         <= found;
        end
        sdt_pkg::OP_READ: begin
          rank        <= '0;
          entry_value <= index_ok ? sdt_pkg::ENTRY_W'(rdata) : '0;
          hit         <= index_ok;
        end
        default: begin
          rank        <= '0;
          entry_value <= '0;
          hit         <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ design/sdt_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted dictionary transform checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module sdt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [sdt_pkg::ENTRY_W-1:0]      entry_value,
  input logic [sdt_pkg::UCOUNT_W-1:0]     unique_count,
  input logic [sdt_pkg::WCODE_W-1:0]      width_code,
  input logic                             hit,
  input logic                             overflow
);

  property p_result_holds;
    @(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid;
  endproperty
  a_result_holds: assert property (p_result_holds)
    else $error("result beat dropped before it was taken");

  property p_busy_after_accept;
    @(posedge clk) disable iff (rst)
      in_valid && in_ready |=> !in_ready;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("request taken while the previous one is still in work");

  property p_width_code;
    @(posedge clk) disable iff (rst)
      out_valid |-> ((32'(unique_count) <= 32'(sdt_pkg::LIMIT_NARROW))
                     == (width_code == sdt_pkg::WIDTH_8));
  endproperty
  a_width_code: assert property (p_width_code)
    else $error("width code does not match the distinct count");

  property p_overflow_full;
    @(posedge clk) disable iff (rst)
      out_valid && overflow |->
        !hit && entry_value == '0
        && 32'(unique_count) == 32'(sdt_pkg::MAX_UNIQUE);
  endproperty
  a_overflow_full: assert property (p_overflow_full)
    else $error("overflow reported without a full table");

endmodule

bind sorted_dictionary_transform sdt_checker u_sdt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .entry_value  (out_ch.entry_value),
  .unique_count (out_ch.unique_count),
  .width_code   (out_ch.width_code),
  .hit          (out_ch.hit),
  .overflow     (out_ch.overflow)
);

@@ verif/tb_sorted_dictionary_transform.sv @@
// ----------------------------------------------------------------------------
// Sorted dictionary transform testbench
// Drives clear, insert, rank and read requests into the block and checks every
// result beat against a local model of the sorted table of distinct values.
// The run has a short directed part, a fill of the table up to overflow, and
// random traffic under several patterns of source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_sorted_dictionary_transform;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sdt_pkg::op_t                 op;
    logic [sdt_pkg::IN_VAL_W-1:0] value;
    logic [sdt_pkg::INDEX_W-1:0]  index;
  } dict_req_t;

  typedef struct packed {
    logic [sdt_pkg::RANK_W-1:0]   rank;
    logic [sdt_pkg::ENTRY_W-1:0]  entry_value;
    logic [sdt_pkg::UCOUNT_W-1:0] unique_count;
    sdt_pkg::width_code_t         width_code;
    logic                         hit;
    logic                         overflow;
  } dict_res_t;

  logic clk;
  logic rst;

  sdt_in_if  in_ch  (.clk(clk));
  sdt_out_if out_ch (.clk(clk));

  sorted_dictionary_transform u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model of the block's table and count.
  logic [31:0] dict_tab [sdt_pkg::MAX_UNIQUE];
  int unsigned dict_cnt = 0;

  dict_req_t   dict_req_q [$];
  dict_res_t   dict_results_q [$];
  logic [31:0] gen_vals [$];

  dict_req_t   next_req;
  dict_req_t   seen_req;
  dict_res_t   want_res;
  logic        in_taken = 1'b0;
  int unsigned queued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  function automatic dict_res_t dict_step(dict_req_t r);
    dict_res_t   res;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    res = '0;
    case (r.op)
      sdt_pkg::OP_CLEAR: begin
        dict_cnt = 0;
      end
      sdt_pkg::OP_READ: begin
        if (r.index < dict_cnt) begin
          res.entry_value = dict_tab[r.index];
          res.hit = 1'b1;
        end
      end
      default: begin
        lo = 0;
        hi = dict_cnt;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (dict_tab[mid] < r.value) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        res.rank = lo[sdt_pkg::RANK_W-1:0];
        if (lo < dict_cnt && dict_tab[lo] == r.value) begin
          res.hit = 1'b1;
        end else if (r.op == sdt_pkg::OP_INSERT) begin
          if (dict_cnt >= sdt_pkg::MAX_UNIQUE) begin
            res.overflow = 1'b1;
          end else begin
            for (int unsigned k = dict_cnt; k > lo; k--) begin
              dict_tab[k] = dict_tab[k-1];
            end
            dict_tab[lo] = r.value;
            dict_cnt++;
          end
        end
      end
    endcase
    res.unique_count = dict_cnt[sdt_pkg::UCOUNT_W-1:0];
    if (dict_cnt <= sdt_pkg::LIMIT_NARROW) begin
      res.width_code = sdt_pkg::WIDTH_8;
    end else if (dict_cnt <= sdt_pkg::LIMIT_MID) begin
      res.width_code = sdt_pkg::WIDTH_16;
    end else begin
      res.width_code = sdt_pkg::WIDTH_32;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic push_req(sdt_pkg::op_t op, logic [31:0] v,
                          logic [sdt_pkg::INDEX_W-1:0] idx);
    dict_req_t r;
    bit        known;
    r.op = op;
    r.value = v;
    r.index = idx;
    dict_req_q.push_back(r);
    queued_cnt++;
    if (op == sdt_pkg::OP_CLEAR) begin
      gen_vals.delete();
    end else if (op == sdt_pkg::OP_INSERT) begin
      known = 1'b0;
      foreach (gen_vals[i]) begin
        if (gen_vals[i] == v) begin
          known = 1'b1;
        end
      end
      if (!known && gen_vals.size() < sdt_pkg::MAX_UNIQUE) begin
        gen_vals.push_back(v);
      end
    end
  endtask

  function automatic logic [sdt_pkg::INDEX_W-1:0] rand_index();
    return sdt_pkg::INDEX_W'($urandom_range(sdt_pkg::MAX_UNIQUE - 1));
  endfunction

  task automatic add_random_request();
    int unsigned                 n;
    int unsigned                 sel;
    logic [31:0]                 v;
    logic [sdt_pkg::INDEX_W-1:0] idx;
    n = gen_vals.size();
    sel = $urandom_range(99);
    v = $urandom;
    idx = rand_index();
    if (sel < 8 || (n >= 64 && sel < 30)) begin
      push_req(sdt_pkg::OP_CLEAR, v, idx);
    end else if (sel < 60) begin
      case ($urandom_range(3))
        0: if (n > 0) v = gen_vals[$urandom_range(n - 1)];
        1: v = $urandom_range(63);
        2: v = 32'hFFFF_FFC0 | $urandom_range(63);
        default: ;
      endcase
      push_req(sdt_pkg::OP_INSERT, v, idx);
    end else if (sel < 80) begin
      if (n > 0 && $urandom_range(2) != 0) begin
        v = gen_vals[$urandom_range(n - 1)];
        if ($urandom_range(1) == 0) begin
          v = ($urandom_range(1) == 0) ? v + 32'd1 : v - 32'd1;
        end
      end
      push_req(sdt_pkg::OP_RANK, v, idx);
    end else begin
      if ($urandom_range(3) != 0) begin
        idx = sdt_pkg::INDEX_W'($urandom_range(n + 2 < sdt_pkg::MAX_UNIQUE ?
                                               n + 2 : sdt_pkg::MAX_UNIQUE - 1));
      end
      push_req(sdt_pkg::OP_READ, v, idx);
    end
  endtask

  task automatic wait_drained();
    while (taken_cnt != queued_cnt || results_seen != taken_cnt) begin
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Request driver: a beat is held until accepted, then the next one or a gap follows.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (dict_req_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        next_req = dict_req_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op    <= next_req.op;
        in_ch.value <= next_req.value;
        in_ch.index <= next_req.index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: checks result beats in order and predicts each accepted request beat.
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (dict_results_q.size() == 0) begin
          $error("result beat with no request outstanding");
          err_cnt++;
        end else begin
          want_res = dict_results_q.pop_front();
          results_seen <= results_seen + 1;
          check_field("rank", want_res.rank, out_ch.rank);
          check_field("entry_value", want_res.entry_value, out_ch.entry_value);
          check_field("unique_count", want_res.unique_count, out_ch.unique_count);
          check_field("width_code", want_res.width_code, out_ch.width_code);
          check_field("hit", want_res.hit, out_ch.hit);
          check_field("overflow", want_res.overflow, out_ch.overflow);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_req.op = sdt_pkg::op_t'(in_ch.op);
        seen_req.value = in_ch.value;
        seen_req.index = in_ch.index;
        dict_results_q.push_back(dict_step(seen_req));
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.op = sdt_pkg::OP_CLEAR;
    in_ch.value = '0;
    in_ch.index = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty table, table ends, duplicates, misses and clears.
    src_idle_pct = 0;
    sink_stall_pct = 0;
    push_req(sdt_pkg::OP_RANK, 32'h0000_0000, 10'd0);
    push_req(sdt_pkg::OP_READ, 32'h0000_0000, 10'd0);
    push_req(sdt_pkg::OP_INSERT, 32'h8000_0000, 10'd0);
    push_req(sdt_pkg::OP_INSERT, 32'hFFFF_FFFF, 10'd0);
    push_req(sdt_pkg::OP_INSERT, 32'h0000_0000, 10'd0);
    push_req(sdt_pkg::OP_INSERT, 32'h8000_0000, 10'd0);
    push_req(sdt_pkg::OP_INSERT, 32'h7FFF_FFFF, 10'd0);
    push_req(sdt_pkg::OP_RANK, 32'hFFFF_FFFF, 10'd0);
    push_req(sdt_pkg::OP_RANK, 32'hFFFF_FFFE, 10'd0);
    push_req(sdt_pkg::OP_RANK, 32'h0000_0000, 10'd0);
    push_req(sdt_pkg::OP_RANK, 32'h0000_0001, 10'd0);
    push_req(sdt_pkg::OP_READ, 32'h0000_0000, 10'd0);
    push_req(sdt_pkg::OP_READ, 32'hFFFF_FFFF, 10'd3);
    push_req(sdt_pkg::OP_READ, 32'h0000_0000, 10'd4);
    push_req(sdt_pkg::OP_READ, 32'h0000_0000, 10'h3FF);
    push_req(sdt_pkg::OP_CLEAR, 32'hFFFF_FFFF, 10'h3FF);
    push_req(sdt_pkg::OP_READ, 32'h0000_0000, 10'd0);
    push_req(sdt_pkg::OP_RANK, 32'h5555_5555, 10'd0);
    push_req(sdt_pkg::OP_INSERT, 32'h5555_5555, 10'h3FF);
    push_req(sdt_pkg::OP_INSERT, 32'hAAAA_AAAA, 10'h155);
    push_req(sdt_pkg::OP_READ, 32'hAAAA_AAAA, 10'd1);
    push_req(sdt_pkg::OP_CLEAR, 32'h0000_0000, 10'd0);
    wait_drained();

    // Fill the table in ascending order, then force long shifts and overflow.
    src_idle_pct = 15;
    sink_stall_pct = 15;
    push_req(sdt_pkg::OP_CLEAR, $urandom, rand_index());
    for (int i = 0; i < 1000; i++) begin
      push_req(sdt_pkg::OP_INSERT,
               (32'(i) * 32'd4_000_000 + $urandom_range(3_999_999)) & ~32'd1,
               rand_index());
      if (i % 40 == 39) begin
        push_req(sdt_pkg::OP_READ, $urandom, rand_index());
      end
    end
    repeat (28) push_req(sdt_pkg::OP_INSERT, $urandom | 32'd1, rand_index());
    push_req(sdt_pkg::OP_INSERT, $urandom | 32'd1, 10'd0);
    push_req(sdt_pkg::OP_INSERT, gen_vals[0], 10'd0);
    push_req(sdt_pkg::OP_RANK, 32'hFFFF_FFFF, 10'd0);
    push_req(sdt_pkg::OP_INSERT, 32'hFFFF_FFFF, 10'd0);
    push_req(sdt_pkg::OP_READ, 32'h0000_0000, 10'h3FF);
    push_req(sdt_pkg::OP_READ, 32'h0000_0000, 10'd0);
    wait_drained();

    // Random traffic under each idling pattern; the sender pauses between them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
        default: begin src_idle_pct = 15; sink_stall_pct = 15; end
      endcase
      repeat (42) add_random_request();
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sorted_dictionary_transform.f @@
design/sdt_pkg.sv
design/sdt_if.sv
design/sdt_ctrl.sv
design/sdt_datapath.sv
design/sorted_dictionary_transform.sv
design/sdt_checker.sv
verif/tb_sorted_dictionary_transform.sv
